>>> hdl/rau_pkg.sv
// Shared types and constants for the rational arithmetic unit.
package rau_pkg;

    localparam int OPERAND_WIDTH_DEF = 16;

    // Operation codes carried on the input tuser
    localparam logic [2:0] MODE_ADD = 3'd0;
    localparam logic [2:0] MODE_SUB = 3'd1;
    localparam logic [2:0] MODE_MUL = 3'd2;
    localparam logic [2:0] MODE_DIV = 3'd3;
    localparam logic [2:0] MODE_EQ  = 3'd4;
    localparam logic [2:0] MODE_LT  = 3'd5;
    localparam logic [2:0] MODE_GT  = 3'd6;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MUL0,
        ST_MUL1,
        ST_MUL2,
        ST_COMB,
        ST_CHK,
        ST_GCD,
        ST_DIV,
        ST_FIN
    } rau_state_t;

    typedef enum logic [3:0] {
        OP_NOP,
        OP_LOAD,
        OP_MUL0,
        OP_MUL1,
        OP_MUL2,
        OP_COMB,
        OP_GCD,
        OP_DIV_INIT,
        OP_DIV,
        OP_FIN
    } rau_op_t;

    typedef struct packed {
        logic early;
        logic gcd_done;
        logic div_last;
        logic out_free;
    } rau_status_t;

endpackage

>>> hdl/rau_ctrl.sv
// Sequencer for the rational arithmetic unit.
module rau_ctrl
    import rau_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  rau_status_t status,
    output rau_op_t     op
);

    rau_state_t state_reg;
    rau_state_t state_next;

    // State register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // Next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: if (s_tvalid) state_next = ST_MUL0;
            ST_MUL0: state_next = ST_MUL1;
            ST_MUL1: state_next = ST_MUL2;
            ST_MUL2: state_next = ST_COMB;
            ST_COMB: state_next = ST_CHK;
            ST_CHK: begin
                if (status.early) state_next = ST_FIN;
                else              state_next = ST_GCD;
            end
            ST_GCD: if (status.gcd_done) state_next = ST_DIV;
            ST_DIV: if (status.div_last) state_next = ST_FIN;
            ST_FIN: if (status.out_free) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    // Datapath commands
    always_comb begin
        op       = OP_NOP;
        s_tready = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) op = OP_LOAD;
            end
            ST_MUL0: op = OP_MUL0;
            ST_MUL1: op = OP_MUL1;
            ST_MUL2: op = OP_MUL2;
            ST_COMB: op = OP_COMB;
            ST_CHK:  op = OP_NOP;
            ST_GCD: begin
                if (status.gcd_done) op = OP_DIV_INIT;
                else                 op = OP_GCD;
            end
            ST_DIV: op = OP_DIV;
            ST_FIN: if (status.out_free) op = OP_FIN;
            default: op = OP_NOP;
        endcase
    end

endmodule

>>> hdl/rau_datapath.sv
// Multiplier, gcd and divider datapath of the rational arithmetic unit.
module rau_datapath
    import rau_pkg::*;
#(
    parameter int OPERAND_WIDTH = OPERAND_WIDTH_DEF
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  rau_op_t                  op,
    output rau_status_t              status,
    input  logic [2:0]               mode_in,
    input  logic [OPERAND_WIDTH-1:0] a_num,
    input  logic [OPERAND_WIDTH-1:0] a_den,
    input  logic [OPERAND_WIDTH-1:0] b_num,
    input  logic [OPERAND_WIDTH-1:0] b_den,
    output logic [63:0]              out_data,
    output logic [2:0]               out_user,
    output logic                     out_valid,
    input  logic                     out_ready
);

    localparam int W  = OPERAND_WIDTH;
    localparam int MW = 2 * OPERAND_WIDTH;
    localparam int EW = (MW > 32) ? MW : 32;
    localparam int CW = $clog2(MW);

    typedef logic [W-1:0]  opmag_t;
    typedef logic [MW-1:0] mag_t;

    function automatic opmag_t mag_of(input logic [W-1:0] v);
        return v[W-1] ? (~v + 1'b1) : v;
    endfunction

    function automatic logic signed [MW:0] to_sv(input logic neg, input mag_t mag);
        logic signed [MW:0] e;
        e = $signed({1'b0, mag});
        return neg ? -e : e;
    endfunction

    function automatic logic outside32(input logic neg, input mag_t mag);
        logic [64:0] e;
        e = 65'(mag);
        return neg ? (e > 65'h0_8000_0000) : (e > 65'h0_7FFF_FFFF);
    endfunction

    function automatic logic [31:0] out32(input logic neg, input mag_t mag);
        logic [EW-1:0] e;
        logic [EW-1:0] v;
        e = EW'(mag);
        v = neg ? (~e + 1'b1) : e;
        return v[31:0];
    endfunction

    // Operand and product registers
    logic [2:0] mode_reg;
    opmag_t     an_mag_reg, ad_mag_reg, bn_mag_reg, bd_mag_reg;
    logic       an_neg_reg, ad_neg_reg, bn_neg_reg, bd_neg_reg;
    mag_t       p0_mag_reg, p1_mag_reg, p2_mag_reg;
    logic       p0_neg_reg, p1_neg_reg, p2_neg_reg;

    // Reduction registers
    logic       num_neg_reg, den_neg_reg;
    mag_t       ga_reg, gb_reg, nm_reg, dm_reg;
    mag_t       qn_reg, qd_reg;
    logic [MW:0] rn_rem_reg, rd_rem_reg;
    logic [CW-1:0] cnt_reg;

    // Early result registers
    logic        early_reg;
    logic [31:0] rn_e_reg, rd_e_reg;
    logic        cmp_reg, zerr_reg, ovf_reg;

    // Output register
    logic [63:0] out_data_reg;
    logic [2:0]  out_user_reg;
    logic        out_vld_reg;

    // Shared multiplier operand select
    opmag_t mx, my;
    logic   mx_neg, my_neg;
    mag_t   prod;
    logic   prod_neg;

    always_comb begin
        unique case (op)
            OP_MUL0: begin
                mx     = an_mag_reg;
                mx_neg = an_neg_reg;
                my     = (mode_reg == MODE_MUL) ? bn_mag_reg : bd_mag_reg;
                my_neg = (mode_reg == MODE_MUL) ? bn_neg_reg : bd_neg_reg;
            end
            OP_MUL1: begin
                mx     = bn_mag_reg;
                mx_neg = bn_neg_reg;
                my     = ad_mag_reg;
                my_neg = ad_neg_reg;
            end
            default: begin
                mx     = ad_mag_reg;
                mx_neg = ad_neg_reg;
                my     = (mode_reg == MODE_DIV) ? bn_mag_reg : bd_mag_reg;
                my_neg = (mode_reg == MODE_DIV) ? bn_neg_reg : bd_neg_reg;
            end
        endcase
        prod     = MW'(mx) * MW'(my);
        prod_neg = (mx_neg ^ my_neg) && (prod != '0);
    end

    // Combine products into numerator, denominator and compare outcome
    logic signed [MW:0]   l_sv, r_sv;
    logic signed [MW+1:0] sum, sum_abs;
    logic                 sum_neg;
    logic                 c_num_neg;
    mag_t                 c_num_mag;
    logic                 c_cmp;
    logic                 is_addsub;

    always_comb begin
        l_sv      = to_sv(p0_neg_reg, p0_mag_reg);
        r_sv      = to_sv(p1_neg_reg, p1_mag_reg);
        is_addsub = (mode_reg == MODE_ADD) || (mode_reg == MODE_SUB);
        if (mode_reg == MODE_SUB) sum = {l_sv[MW], l_sv} - {r_sv[MW], r_sv};
        else                      sum = {l_sv[MW], l_sv} + {r_sv[MW], r_sv};
        sum_neg = sum[MW+1];
        sum_abs = sum_neg ? -sum : sum;
        if (is_addsub) begin
            c_num_neg = sum_neg;
            c_num_mag = sum_abs[MW-1:0];
        end else begin
            c_num_neg = p0_neg_reg;
            c_num_mag = p0_mag_reg;
        end
        unique case (mode_reg)
            MODE_EQ: c_cmp = (l_sv == r_sv);
            MODE_LT: c_cmp = (l_sv < r_sv);
            MODE_GT: c_cmp = (l_sv > r_sv);
            default: c_cmp = 1'b0;
        endcase
    end

    // Binary gcd step, dividends shifted along while both are even
    mag_t ga_step, gb_step, nm_step, dm_step;
    logic gcd_done;

    always_comb begin
        ga_step  = ga_reg;
        gb_step  = gb_reg;
        nm_step  = nm_reg;
        dm_step  = dm_reg;
        gcd_done = ga_reg[0] && gb_reg[0] && (ga_reg == gb_reg);
        priority if (!ga_reg[0] && !gb_reg[0]) begin
            ga_step = ga_reg >> 1;
            gb_step = gb_reg >> 1;
            nm_step = nm_reg >> 1;
            dm_step = dm_reg >> 1;
        end else if (!ga_reg[0]) begin
            ga_step = ga_reg >> 1;
        end else if (!gb_reg[0]) begin
            gb_step = gb_reg >> 1;
        end else if (ga_reg > gb_reg) begin
            ga_step = (ga_reg - gb_reg) >> 1;
        end else if (gb_reg > ga_reg) begin
            gb_step = (gb_reg - ga_reg) >> 1;
        end else begin
            ga_step = ga_reg;
        end
    end

    // Restoring division step, numerator and denominator side by side
    logic [MW:0] rn_sh, rd_sh, div_ext;
    logic        n_ge, d_ge;

    always_comb begin
        div_ext = {1'b0, ga_reg};
        rn_sh   = {rn_rem_reg[MW-1:0], qn_reg[MW-1]};
        rd_sh   = {rd_rem_reg[MW-1:0], qd_reg[MW-1]};
        n_ge    = (rn_sh >= div_ext);
        d_ge    = (rd_sh >= div_ext);
    end

    // Datapath registers
    always_ff @(posedge aclk) begin
        unique case (op)
            OP_LOAD: begin
                mode_reg   <= mode_in;
                an_mag_reg <= mag_of(a_num);
                ad_mag_reg <= mag_of(a_den);
                bn_mag_reg <= mag_of(b_num);
                bd_mag_reg <= mag_of(b_den);
                an_neg_reg <= a_num[W-1];
                ad_neg_reg <= a_den[W-1];
                bn_neg_reg <= b_num[W-1];
                bd_neg_reg <= b_den[W-1];
            end
            OP_MUL0: begin
                p0_mag_reg <= prod;
                p0_neg_reg <= prod_neg;
            end
            OP_MUL1: begin
                p1_mag_reg <= prod;
                p1_neg_reg <= prod_neg;
            end
            OP_MUL2: begin
                p2_mag_reg <= prod;
                p2_neg_reg <= prod_neg;
            end
            OP_COMB: begin
                num_neg_reg <= c_num_neg;
                den_neg_reg <= p2_neg_reg;
                ga_reg      <= c_num_mag;
                gb_reg      <= p2_mag_reg;
                nm_reg      <= c_num_mag;
                dm_reg      <= p2_mag_reg;
                cmp_reg     <= 1'b0;
                zerr_reg    <= 1'b0;
                ovf_reg     <= 1'b0;
                rn_e_reg    <= 32'd0;
                rd_e_reg    <= 32'd1;
                early_reg   <= 1'b1;
                priority if (mode_reg[2]) begin
                    cmp_reg <= c_cmp;
                end else if (p2_mag_reg == '0) begin
                    zerr_reg <= 1'b1;
                    rd_e_reg <= 32'd0;
                end else begin
                    ovf_reg   <= outside32(c_num_neg, c_num_mag)
                               || outside32(p2_neg_reg, p2_mag_reg);
                    early_reg <= (c_num_mag == '0);
                end
            end
            OP_GCD: begin
                ga_reg <= ga_step;
                gb_reg <= gb_step;
                nm_reg <= nm_step;
                dm_reg <= dm_step;
            end
            OP_DIV_INIT: begin
                qn_reg     <= nm_reg;
                qd_reg     <= dm_reg;
                rn_rem_reg <= '0;
                rd_rem_reg <= '0;
                cnt_reg    <= '0;
            end
            OP_DIV: begin
                rn_rem_reg <= n_ge ? (rn_sh - div_ext) : rn_sh;
                rd_rem_reg <= d_ge ? (rd_sh - div_ext) : rd_sh;
                qn_reg     <= {qn_reg[MW-2:0], n_ge};
                qd_reg     <= {qd_reg[MW-2:0], d_ge};
                cnt_reg    <= cnt_reg + 1'b1;
            end
            OP_FIN: begin
                if (early_reg) out_data_reg <= {rd_e_reg, rn_e_reg};
                else out_data_reg <= {out32(den_neg_reg, qd_reg),
                                      out32(num_neg_reg, qn_reg)};
                out_user_reg <= {ovf_reg, zerr_reg, cmp_reg};
            end
            default: begin
                mode_reg <= mode_reg;
            end
        endcase
    end

    // Hold the result until the sink takes it
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_vld_reg <= 1'b0;
        end else if (op == OP_FIN) begin
            out_vld_reg <= 1'b1;
        end else if (out_ready) begin
            out_vld_reg <= 1'b0;
        end
    end

    assign status.early    = early_reg;
    assign status.gcd_done = gcd_done;
    assign status.div_last = (cnt_reg == CW'(MW - 1));
    assign status.out_free = !out_vld_reg || out_ready;

    assign out_data  = out_data_reg;
    assign out_user  = out_user_reg;
    assign out_valid = out_vld_reg;

endmodule

>>> hdl/rational_arith_unit_core.sv
// Sequence: load, multiply steps MUL0 to MUL2, combine, check, then the gcd loop,
// 2*OPERAND_WIDTH divide steps and the load of the output register.
// Compare modes, zero results and zero denominators skip the gcd loop and divider.
// One item at a time: the next item is taken once the result is in the output
// register; the shared multiplier, gcd loop and bit-serial divider set the rate.
// Reset: synchronous, active low aresetn clears the sequencer and output valid.
module rational_arith_unit_core
    import rau_pkg::*;
#(
    parameter int OPERAND_WIDTH = OPERAND_WIDTH_DEF
) (
    input  logic                                       aclk,
    input  logic                                       aresetn,
    input  logic                                       s_tvalid,
    output logic                                       s_tready,
    // a_num, a_den, b_num, b_den from the lowest bit up, zero padded
    input  logic [((4*OPERAND_WIDTH+7)/8)*8-1:0]      s_tdata,
    // mode
    input  logic [2:0]                                 s_tuser,
    output logic                                       m_tvalid,
    input  logic                                       m_tready,
    // res_num, res_den from the lowest bit up
    output logic [63:0]                                m_tdata,
    // cmp_true, zero_den_error, overflow from the lowest bit up
    output logic [2:0]                                 m_tuser
);

    localparam int W = OPERAND_WIDTH;

    rau_op_t     op;
    rau_status_t status;

    rau_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .op       (op)
    );

    rau_datapath #(
        .OPERAND_WIDTH (OPERAND_WIDTH)
    ) u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .op        (op),
        .status    (status),
        .mode_in   (s_tuser),
        .a_num     (s_tdata[W-1:0]),
        .a_den     (s_tdata[2*W-1:W]),
        .b_num     (s_tdata[3*W-1:2*W]),
        .b_den     (s_tdata[4*W-1:3*W]),
        .out_data  (m_tdata),
        .out_user  (m_tuser),
        .out_valid (m_tvalid),
        .out_ready (m_tready)
    );

`ifndef ASSERT_OFF
    // No second item is taken straight after one
    a_one_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("item accepted while previous one in progress");

    // A zero denominator result is all zeros
    a_zero_den_result: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[1] |-> (m_tdata == 64'd0) && !m_tuser[2] && !m_tuser[0])
        else $error("zero denominator result not cleared");

    // Comparison outcome comes with 0/1
    a_cmp_result: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[0] |-> (m_tdata == 64'h0000_0001_0000_0000))
        else $error("comparison result not 0/1");
`endif

endmodule

>>> sim/rational_arith_unit_core_test.sv
// Self-checking testbench for the rational arithmetic unit core.
module rational_arith_unit_core_test;
    import rau_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int W  = OPERAND_WIDTH_DEF;
    localparam int DW = ((4*W+7)/8)*8;

    typedef struct packed {
        logic [31:0] num;
        logic [31:0] den;
        logic        cmp;
        logic        zden;
        logic        ovf;
    } quotient_t;

    logic          aclk;
    logic          aresetn;
    logic          s_tvalid;
    logic          s_tready;
    logic [DW-1:0] s_tdata;
    logic [2:0]    s_tuser;
    logic          m_tvalid;
    logic          m_tready;
    logic [63:0]   m_tdata;
    logic [2:0]    m_tuser;

    quotient_t quotients_due[$];
    int        err_count;
    int        send_idle_pct;
    int        recv_idle_pct;
    int        hold_off;
    logic      hold_req;
    logic      hold_done;

    rational_arith_unit_core u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    // 20 ns clock
    always begin
        aclk = 1'b0;
        #10;
        aclk = 1'b1;
        #10;
    end

    // Work out the result of one item with exact 64-bit arithmetic
    function automatic quotient_t calc_quotient(logic [2:0] mode, logic signed [W-1:0] an,
                                                logic signed [W-1:0] ad,
                                                logic signed [W-1:0] bn,
                                                logic signed [W-1:0] bd);
        quotient_t r;
        longint n, d, p, q, ga, gb, t;
        r = '{num: 32'd0, den: 32'd1, cmp: 1'b0, zden: 1'b0, ovf: 1'b0};
        p = longint'(an) * longint'(bd);
        q = longint'(bn) * longint'(ad);
        if (mode >= MODE_EQ) begin
            if (mode == MODE_EQ) r.cmp = (p == q);
            else if (mode == MODE_LT) r.cmp = (p < q);
            else if (mode == MODE_GT) r.cmp = (p > q);
            return r;
        end
        case (mode)
            MODE_ADD: begin n = p + q; d = longint'(ad) * longint'(bd); end
            MODE_SUB: begin n = p - q; d = longint'(ad) * longint'(bd); end
            MODE_MUL: begin
                n = longint'(an) * longint'(bn);
                d = longint'(ad) * longint'(bd);
            end
            default: begin n = p; d = longint'(ad) * longint'(bn); end
        endcase
        if (d == 0) begin
            r.den = 32'd0;
            r.zden = 1'b1;
            return r;
        end
        r.ovf = (n > 64'sd2147483647) || (n < -64'sd2147483648) ||
                (d > 64'sd2147483647) || (d < -64'sd2147483648);
        if (n == 0) return r;
        ga = (n < 0) ? -n : n;
        gb = (d < 0) ? -d : d;
        while (gb != 0) begin
            t = ga % gb;
            ga = gb;
            gb = t;
        end
        r.num = 32'(n / ga);
        r.den = 32'(d / ga);
        return r;
    endfunction

    // Offer one item, idling at random first, and hold it until taken
    task automatic send_fraction_pair(logic [2:0] mode, logic [W-1:0] an, logic [W-1:0] ad,
                                      logic [W-1:0] bn, logic [W-1:0] bd);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= mode;
        s_tdata  <= DW'({bd, bn, ad, an});
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        quotients_due.push_back(calc_quotient(mode, an, ad, bn, bd));
    endtask

    // Drop the offer and wait until every result is back
    task automatic drain_results();
        s_tvalid <= 1'b0;
        while (quotients_due.size() != 0) @(posedge aclk);
        repeat (150) @(posedge aclk);
    endtask

    function automatic logic [W-1:0] pick_operand();
        case ($urandom_range(7))
            0: return {1'b1, {(W-1){1'b0}}};
            1: return {1'b0, {(W-1){1'b1}}};
            2: return W'($urandom_range(3)) - W'(1);
            3, 4: return W'($urandom_range(40)) - W'(20);
            default: return W'($urandom);
        endcase
    endfunction

    // Extremes, every mode, zero numerator and zero denominator
    task automatic test_directed();
        logic [W-1:0] mn, mx;
        mn = {1'b1, {(W-1){1'b0}}};
        mx = {1'b0, {(W-1){1'b1}}};
        for (int m = 0; m < 8; m++) send_fraction_pair(3'(m), W'(3), W'(4), W'(-5), W'(6));
        send_fraction_pair(MODE_ADD, mn, mn, mn, mn);
        send_fraction_pair(MODE_MUL, mn, W'(1), mn, W'(1));
        send_fraction_pair(MODE_SUB, mx, mn, mn, mx);
        send_fraction_pair(MODE_DIV, mx, W'(-1), W'(0), W'(5));
        send_fraction_pair(MODE_DIV, W'(7), W'(0), W'(2), W'(3));
        send_fraction_pair(MODE_ADD, W'(0), W'(3), W'(0), W'(-7));
        send_fraction_pair(MODE_SUB, W'(2), W'(4), W'(1), W'(2));
        send_fraction_pair(MODE_EQ, W'(1), W'(0), W'(2), W'(0));
        send_fraction_pair(MODE_LT, mn, W'(1), mx, W'(1));
        send_fraction_pair(MODE_GT, mx, mn, W'(-1), W'(-1));
        send_fraction_pair(MODE_MUL, W'(-1), W'(-1), W'(-1), W'(-1));
        send_fraction_pair(MODE_ADD, W'(-1), W'(-1), W'(-1), W'(-1));
        drain_results();
    endtask

    task automatic test_random(int n_items);
        for (int i = 0; i < n_items; i++)
            send_fraction_pair(3'($urandom_range(7)), pick_operand(), pick_operand(),
                               pick_operand(), pick_operand());
    endtask

    // Stall the output for a long stretch while items keep coming
    task automatic test_backpressure();
        hold_req = 1'b1;
        test_random(12);
        drain_results();
    endtask

    // Pause the sender until the block has emptied
    task automatic test_pause();
        test_random(10);
        drain_results();
        test_random(10);
        drain_results();
    endtask

    // Receiver: random stall, one long hold-off when asked
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready  <= 1'b0;
            hold_off  <= 0;
            hold_done <= 1'b0;
        end else if (hold_req && !hold_done) begin
            hold_done <= 1'b1;
            hold_off  <= 600;
            m_tready  <= 1'b0;
        end else if (hold_off > 0) begin
            hold_off <= hold_off - 1;
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Compare each result with the oldest expectation
    always @(posedge aclk) begin
        quotient_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (quotients_due.size() == 0) begin
                $display("%t: unexpected result %h %h", $time, m_tdata, m_tuser);
                err_count++;
            end else begin
                want = quotients_due.pop_front();
                if (m_tdata[31:0] !== want.num) begin
                    $display("%t: res_num exp %h got %h", $time, want.num, m_tdata[31:0]);
                    err_count++;
                end
                if (m_tdata[63:32] !== want.den) begin
                    $display("%t: res_den exp %h got %h", $time, want.den, m_tdata[63:32]);
                    err_count++;
                end
                if (m_tuser[0] !== want.cmp) begin
                    $display("%t: cmp_true exp %b got %b", $time, want.cmp, m_tuser[0]);
                    err_count++;
                end
                if (m_tuser[1] !== want.zden) begin
                    $display("%t: zero_den_error exp %b got %b", $time, want.zden, m_tuser[1]);
                    err_count++;
                end
                if (m_tuser[2] !== want.ovf) begin
                    $display("%t: overflow exp %b got %b", $time, want.ovf, m_tuser[2]);
                    err_count++;
                end
            end
        end
    end

    // Guard against a hang
    initial begin
        #20ms;
        $display("Simulation FAILED");
        $finish;
    end

    initial begin
        err_count = 0;
        hold_req = 1'b0;
        send_idle_pct = 28;
        recv_idle_pct = 47;
        aresetn  = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        s_tuser  = '0;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_directed();
        test_backpressure();
        test_pause();
        test_random(500);
        send_idle_pct = 47;
        recv_idle_pct = 28;
        test_random(500);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_random(450);
        drain_results();
        if (err_count == 0 && quotients_due.size() == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end
endmodule

>>> files.f
hdl/rau_pkg.sv
hdl/rau_ctrl.sv
hdl/rau_datapath.sv
hdl/rational_arith_unit_core.sv
sim/rational_arith_unit_core_test.sv
